// ===== sv/selective_repeat_sender_tracker_core_macros.svh =====
// Assertion helpers for the sender tracker.
`ifndef SELECTIVE_REPEAT_SENDER_TRACKER_CORE_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_TRACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SRST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srst same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SRST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srst next-cycle check failed");
`else
`define SRST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SRST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/srst_pkg.sv =====
package srst_pkg;

  // Sizing of the transfer.
  localparam int MAX_CHUNKS  = 64;
  localparam int CHUNK_BYTES = 5;
  localparam int LIMIT_BYTES = MAX_CHUNKS * CHUNK_BYTES;

  // Internal widths derived from the sizing.
  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int EFF_W = $clog2(LIMIT_BYTES + 1);
  localparam int LEN_W = (EFF_W > 9) ? EFF_W : 9;

  // Chunk count as ceil(length / CHUNK_BYTES) by reciprocal multiplication.
  // The shift is wide enough for the result to be exact over the whole range.
  localparam int DIVD_W      = $clog2(LIMIT_BYTES + CHUNK_BYTES);
  localparam int RECIP_SHIFT = DIVD_W + $clog2(CHUNK_BYTES);
  localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int RECIP_W     = $clog2(RECIP_MUL + 1);
  localparam int PROD_W      = DIVD_W + RECIP_W;

  // Port field widths.
  localparam int FUNC_W     = 2;
  localparam int ACK_W      = 6;
  localparam int TIME_W     = 32;
  localparam int MSGLEN_W   = 9;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int KIND_W     = 2;
  localparam int OIDX_W     = 6;
  localparam int OOFF_W     = 9;
  localparam int OCNT_W     = 3;
  localparam int OTOT_W     = 7;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;

  // Operation codes of an input item.
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POLL  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SEND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  // Write request into the timestamp memory.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [TIME_W-1:0] data;
  } stamp_wr_t;

endpackage

// ===== sv/srst_stamp_ram.sv =====
module srst_stamp_ram (
  input  logic                      clk,
  input  srst_pkg::stamp_wr_t       wr,
  input  logic                      rd_en,
  input  logic [srst_pkg::IDX_W-1:0] rd_addr,
  output logic [srst_pkg::TIME_W-1:0] rd_data
);
  import srst_pkg::*;

  logic [TIME_W-1:0] mem [MAX_CHUNKS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/srst_elapsed_cmp.sv =====
module srst_elapsed_cmp (
  input  logic [srst_pkg::TIME_W-1:0]    now_ms,
  input  logic [srst_pkg::TIME_W-1:0]    stamp_ms,
  input  logic [srst_pkg::TIMEOUT_W-1:0] timeout_ms,
  output logic                           expired
);
  import srst_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // Elapsed time wraps modulo 2^32, then is checked against the threshold.
  assign elapsed = now_ms - stamp_ms;
  assign expired = elapsed > TIME_W'(timeout_ms);

endmodule

// ===== sv/selective_repeat_sender_tracker_core.sv =====
// Sender tracker: an ack item is handled in the idle state; a start counts the chunks,
// then sends one chunk per cycle unless out_ready stalls (N chunks, at most 64).
// An active poll scans timestamp memory chunk by chunk (registered read, then compare)
// and then flushes; in_ready is low throughout. Reset (rst_n low, synchronous)
// clears the sequencer, ack map, transfer state and length register, sets the
// timeout to 200; timestamp memory is not cleared, each chunk is stamped at start.
module selective_repeat_sender_tracker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [srst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srst_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srst_pkg::FUNC_W-1:0]       in_func,
  input  logic [srst_pkg::ACK_W-1:0]        in_ack_index,
  input  logic [srst_pkg::TIME_W-1:0]       in_now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srst_pkg::KIND_W-1:0]       out_kind,
  output logic [srst_pkg::OIDX_W-1:0]       out_chunk_index,
  output logic [srst_pkg::OOFF_W-1:0]       out_byte_offset,
  output logic [srst_pkg::OCNT_W-1:0]       out_byte_count,
  output logic [srst_pkg::OTOT_W-1:0]       out_chunk_total,
  output logic                              out_last
);
  import srst_pkg::*;
  `include "selective_repeat_sender_tracker_core_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_SEND,
    S_RD,
    S_CMP,
    S_FLUSH
  } state_t;

  state_t               state_r, state_nxt;
  logic [MSGLEN_W-1:0]  msg_len_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [MAX_CHUNKS-1:0] acked_r, acked_nxt;
  logic                 active_r, active_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [EFF_W-1:0]     eff_r, eff_nxt;
  logic [EFF_W-1:0]     off_r, off_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic                 all_acked_r, all_acked_nxt;
  logic                 held_v_r, held_v_nxt;
  logic [IDX_W-1:0]     held_idx_r, held_idx_nxt;
  logic [EFF_W-1:0]     held_off_r, held_off_nxt;
  logic [OCNT_W-1:0]    held_cnt_r, held_cnt_nxt;

  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [OIDX_W-1:0]    out_idx_r;
  logic [OOFF_W-1:0]    out_off_r;
  logic [OCNT_W-1:0]    out_cnt_r;
  logic [OTOT_W-1:0]    out_tot_r;
  logic                 out_last_r;

  logic                 push;
  logic [KIND_W-1:0]    push_kind;
  logic [OIDX_W-1:0]    push_idx;
  logic [OOFF_W-1:0]    push_off;
  logic [OCNT_W-1:0]    push_cnt;
  logic                 push_last;

  logic                 in_acc;
  logic                 can_push;
  logic [LEN_W-1:0]     len_ext;
  logic [EFF_W-1:0]     eff_clamp;
  logic [DIVD_W-1:0]    div_num;
  logic [PROD_W-1:0]    chunk_prod;
  logic [CNT_W-1:0]     chunk_cnt;
  logic [EFF_W-1:0]     off_inc;
  logic [EFF_W-1:0]     rest;
  logic [EFF_W-1:0]     cur_cnt;
  logic                 is_last;
  logic                 unacked;
  logic                 hit;
  logic                 expired;
  logic                 out_is_cmd;
  stamp_wr_t            stamp_wr;
  logic                 rd_en;
  logic [TIME_W-1:0]    rd_data;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign can_push = ~out_valid_r | out_ready;

  // Message length clamped to what the chunk table can hold.
  assign len_ext   = LEN_W'(msg_len_r);
  assign eff_clamp = (len_ext > LEN_W'(LIMIT_BYTES)) ? EFF_W'(LIMIT_BYTES)
                                                     : EFF_W'(msg_len_r);

  // Chunk count rounded up: multiply by the scaled reciprocal, then shift.
  assign div_num    = DIVD_W'(eff_r) + DIVD_W'(CHUNK_BYTES - 1);
  assign chunk_prod = PROD_W'(div_num) * PROD_W'(RECIP_MUL);
  assign chunk_cnt  = CNT_W'(chunk_prod >> RECIP_SHIFT);

  // Shared offset adder and byte count of the chunk at the current offset.
  assign off_inc = off_r + EFF_W'(CHUNK_BYTES);
  assign rest    = eff_r - off_r;
  assign cur_cnt = (rest < EFF_W'(CHUNK_BYTES)) ? rest : EFF_W'(CHUNK_BYTES);
  assign is_last = (CNT_W'(idx_r) == (total_r - CNT_W'(1)));
  assign unacked = ~acked_r[idx_r];
  assign hit     = unacked & expired;

  srst_stamp_ram u_ram (
    .clk     (clk),
    .wr      (stamp_wr),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  srst_elapsed_cmp u_cmp (
    .now_ms     (now_r),
    .stamp_ms   (rd_data),
    .timeout_ms (timeout_r),
    .expired    (expired)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    acked_nxt     = acked_r;
    active_nxt    = active_r;
    total_nxt     = total_r;
    eff_nxt       = eff_r;
    off_nxt       = off_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    all_acked_nxt = all_acked_r;
    held_v_nxt    = held_v_r;
    held_idx_nxt  = held_idx_r;
    held_off_nxt  = held_off_r;
    held_cnt_nxt  = held_cnt_r;
    push          = 1'b0;
    push_kind     = KIND_SEND;
    push_idx      = '0;
    push_off      = '0;
    push_cnt      = '0;
    push_last     = 1'b0;
    stamp_wr      = '0;
    rd_en         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_START: begin
              eff_nxt    = eff_clamp;
              off_nxt    = '0;
              acked_nxt  = '0;
              active_nxt = 1'b1;
              now_nxt    = in_now_ms;
              state_nxt  = S_COUNT;
            end
            FUNC_ACK: begin
              if (active_r && ({1'b0, in_ack_index} < OTOT_W'(total_r))) begin
                acked_nxt[in_ack_index[IDX_W-1:0]] = 1'b1;
              end
            end
            FUNC_POLL: begin
              if (active_r) begin
                idx_nxt       = '0;
                off_nxt       = '0;
                held_v_nxt    = 1'b0;
                all_acked_nxt = 1'b1;
                now_nxt       = in_now_ms;
                state_nxt     = (total_r == '0) ? S_FLUSH : S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Take the chunk count of the clamped length in one step.
      S_COUNT: begin
        total_nxt = chunk_cnt;
        idx_nxt   = '0;
        off_nxt   = '0;
        state_nxt = (chunk_cnt == '0) ? S_IDLE : S_SEND;
      end

      // One first-send item per chunk, stamping each chunk as it goes.
      S_SEND: begin
        if (can_push) begin
          push          = 1'b1;
          push_kind     = KIND_SEND;
          push_idx      = OIDX_W'(idx_r);
          push_off      = OOFF_W'(off_r);
          push_cnt      = OCNT_W'(cur_cnt);
          push_last     = is_last;
          stamp_wr.we   = 1'b1;
          stamp_wr.addr = idx_r;
          stamp_wr.data = now_r;
          idx_nxt       = idx_r + IDX_W'(1);
          off_nxt       = off_inc;
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_CMP;
      end

      // A timed-out chunk is held back until the next one or the flush so the last flag is known.
      S_CMP: begin
        if (!(hit && held_v_r && !can_push)) begin
          if (unacked) begin
            all_acked_nxt = 1'b0;
          end
          if (hit) begin
            if (held_v_r) begin
              push      = 1'b1;
              push_kind = KIND_RESEND;
              push_idx  = OIDX_W'(held_idx_r);
              push_off  = OOFF_W'(held_off_r);
              push_cnt  = held_cnt_r;
              push_last = 1'b0;
            end
            held_v_nxt    = 1'b1;
            held_idx_nxt  = idx_r;
            held_off_nxt  = off_r;
            held_cnt_nxt  = OCNT_W'(cur_cnt);
            stamp_wr.we   = 1'b1;
            stamp_wr.addr = idx_r;
            stamp_wr.data = now_r;
          end
          if (is_last) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            off_nxt   = off_inc;
            state_nxt = S_RD;
          end
        end
      end

      // End of scan: done item, final retransmit, or nothing.
      S_FLUSH: begin
        if (all_acked_r) begin
          if (can_push) begin
            push       = 1'b1;
            push_kind  = KIND_DONE;
            push_last  = 1'b1;
            active_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else if (held_v_r) begin
          if (can_push) begin
            push       = 1'b1;
            push_kind  = KIND_RESEND;
            push_idx   = OIDX_W'(held_idx_r);
            push_off   = OOFF_W'(held_off_r);
            push_cnt   = held_cnt_r;
            push_last  = 1'b1;
            held_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      msg_len_r   <= '0;
      timeout_r   <= TIMEOUT_RESET;
      acked_r     <= '0;
      active_r    <= 1'b0;
      total_r     <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acked_r  <= acked_nxt;
      active_r <= active_nxt;
      total_r  <= total_nxt;
      held_v_r <= held_v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MSG_LEN: msg_len_r <= cfg_data[MSGLEN_W-1:0];
          REG_TIMEOUT: timeout_r <= cfg_data[TIMEOUT_W-1:0];
          default: begin
          end
        endcase
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    eff_r        <= eff_nxt;
    off_r        <= off_nxt;
    idx_r        <= idx_nxt;
    now_r        <= now_nxt;
    all_acked_r  <= all_acked_nxt;
    held_idx_r   <= held_idx_nxt;
    held_off_r   <= held_off_nxt;
    held_cnt_r   <= held_cnt_nxt;
    if (push) begin
      out_kind_r <= push_kind;
      out_idx_r  <= push_idx;
      out_off_r  <= push_off;
      out_cnt_r  <= push_cnt;
      out_tot_r  <= OTOT_W'(total_r);
      out_last_r <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_chunk_index = out_idx_r;
  assign out_byte_offset = out_off_r;
  assign out_byte_count  = out_cnt_r;
  assign out_chunk_total = out_tot_r;
  assign out_last        = out_last_r;

  // A send or retransmit is on the result channel.
  assign out_is_cmd = out_valid & (out_kind != KIND_DONE);

  // A done item always closes its burst.
  `SRST_ASSERT_IMP(a_done_last, clk, rst_n, out_valid && (out_kind == KIND_DONE), out_last)
  // A send or retransmit names a chunk inside the transfer.
  `SRST_ASSERT_IMP(a_idx_range, clk, rst_n, out_is_cmd, out_chunk_index < out_chunk_total)
  // A poll with no transfer running finishes in its accept cycle.
  `SRST_ASSERT_NXT(a_idle_poll, clk, rst_n, in_acc && (in_func == FUNC_POLL) && !active_r, in_ready)
  // A start always passes through the chunk-counting state, so in_ready is low in the cycle after it.
  `SRST_ASSERT_NXT(a_start_busy, clk, rst_n, in_acc && (in_func == FUNC_START), !in_ready)

endmodule

// ===== sim/sender_tracker_checker.sv =====
module sender_tracker_checker
  import srst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [ACK_W-1:0]      in_ack_index,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [KIND_W-1:0]     out_kind,
  input  logic [OIDX_W-1:0]     out_chunk_index,
  input  logic [OOFF_W-1:0]     out_byte_offset,
  input  logic [OCNT_W-1:0]     out_byte_count,
  input  logic [OTOT_W-1:0]     out_chunk_total,
  input  logic                  out_last,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_checked
);

  // One send, resend or done command as it leaves the block.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OIDX_W-1:0] chunk_index;
    logic [OOFF_W-1:0] byte_offset;
    logic [OCNT_W-1:0] byte_count;
    logic [OTOT_W-1:0] chunk_total;
    logic              last;
  } chunk_cmd_t;

  // Commands predicted but not yet seen on the result channel.
  chunk_cmd_t pending_cmds[$];

  // Shadow copy of the registers and of the transfer state.
  logic [MSGLEN_W-1:0]   msg_len_q;
  logic [TIMEOUT_W-1:0]  timeout_q;
  logic [MAX_CHUNKS-1:0] acked_q;
  logic [TIME_W-1:0]     stamp_q [MAX_CHUNKS];
  int unsigned           chunk_cnt;
  int unsigned           eff_bytes;
  bit                    xfer_on;

  int bad_count  = 0;
  int seen_count = 0;

  // Bytes carried by chunk i of the current transfer; the last one may be short.
  function automatic logic [OCNT_W-1:0] chunk_bytes(int unsigned i);
    int unsigned off;
    int unsigned rest;
    off  = i * CHUNK_BYTES;
    rest = (eff_bytes > off) ? eff_bytes - off : 0;
    return (rest < CHUNK_BYTES) ? OCNT_W'(rest) : OCNT_W'(CHUNK_BYTES);
  endfunction

  function automatic chunk_cmd_t make_cmd(logic [KIND_W-1:0] kind, int unsigned i);
    chunk_cmd_t cmd;
    cmd.kind        = kind;
    cmd.chunk_index = OIDX_W'(i);
    cmd.byte_offset = OOFF_W'(i * CHUNK_BYTES);
    cmd.byte_count  = chunk_bytes(i);
    cmd.chunk_total = OTOT_W'(chunk_cnt);
    cmd.last        = 1'b0;
    return cmd;
  endfunction

  // Work out the commands one accepted item causes and queue them in order.
  task automatic predict_item(input logic [FUNC_W-1:0] func, input logic [ACK_W-1:0] ack,
                              input logic [TIME_W-1:0] now);
    chunk_cmd_t        burst[$];
    logic [TIME_W-1:0] elapsed;
    int unsigned       settled;
    int unsigned       i;
    settled = 0;
    case (func)
      FUNC_START: begin
        // Oversized lengths are clamped, so the chunk count saturates.
        eff_bytes = (msg_len_q > LIMIT_BYTES) ? LIMIT_BYTES : msg_len_q;
        chunk_cnt = (eff_bytes + CHUNK_BYTES - 1) / CHUNK_BYTES;
        xfer_on   = 1'b1;
        acked_q   = '0;
        for (i = 0; i < chunk_cnt; i++) begin
          stamp_q[i] = now;
          burst.push_back(make_cmd(KIND_SEND, i));
        end
      end
      FUNC_ACK: begin
        if (xfer_on && ack < chunk_cnt) begin
          acked_q[ack] = 1'b1;
        end
      end
      FUNC_POLL: begin
        if (xfer_on) begin
          for (i = 0; i < chunk_cnt; i++) begin
            if (acked_q[i]) begin
              settled++;
            end else begin
              // Elapsed time is taken modulo 2^32 so the clock may wrap.
              elapsed = now - stamp_q[i];
              if (elapsed > timeout_q) begin
                burst.push_back(make_cmd(KIND_RESEND, i));
                stamp_q[i] = now;
              end
            end
          end
          if (settled == chunk_cnt) begin
            burst.delete();
            burst.push_back({KIND_DONE, OIDX_W'(0), OOFF_W'(0), OCNT_W'(0),
                             OTOT_W'(chunk_cnt), 1'b0});
            xfer_on = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    if (burst.size() > 0) begin
      burst[burst.size() - 1].last = 1'b1;
    end
    foreach (burst[k]) begin
      pending_cmds.push_back(burst[k]);
    end
  endtask

  // Results are compared before the same edge's item is predicted; neither can
  // depend on the other in the same cycle.
  always @(posedge clk) begin
    chunk_cmd_t got;
    chunk_cmd_t want;
    if (!rst_n) begin
      msg_len_q = '0;
      timeout_q = TIMEOUT_RESET;
      acked_q   = '0;
      chunk_cnt = 0;
      eff_bytes = 0;
      xfer_on   = 1'b0;
      pending_cmds.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_kind, out_chunk_index, out_byte_offset, out_byte_count,
               out_chunk_total, out_last};
        seen_count++;
        if (pending_cmds.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("[%0t] unexpected result: kind %0d index %0d offset %0d count %0d",
                     $realtime, got.kind, got.chunk_index, got.byte_offset, got.byte_count,
                     " total %0d last %0d", got.chunk_total, got.last);
          end
        end else begin
          want = pending_cmds.pop_front();
          if (got !== want) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("[%0t] result %0d mismatch: expected kind %0d index %0d offset %0d",
                       $realtime, seen_count, want.kind, want.chunk_index, want.byte_offset,
                       " count %0d total %0d last %0d", want.byte_count, want.chunk_total,
                       want.last);
              $display("    got kind %0d index %0d offset %0d count %0d total %0d last %0d",
                       got.kind, got.chunk_index, got.byte_offset, got.byte_count,
                       got.chunk_total, got.last);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MSG_LEN) begin
          msg_len_q = cfg_data[MSGLEN_W-1:0];
        end else if (cfg_index == REG_TIMEOUT) begin
          timeout_q = cfg_data[TIMEOUT_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        predict_item(in_func, in_ack_index, in_now_ms);
      end
    end
    mismatches      <= bad_count;
    outstanding     <= pending_cmds.size();
    results_checked <= seen_count;
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import srst_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Idle time after the last result before registers change; covers a full poll scan.
  localparam int SETTLE_CYCLES    = 200;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int RANDOM_ITEMS     = 300;

  // Receiver behaviors.
  localparam int RX_OPEN   = 0;
  localparam int RX_HALF   = 1;
  localparam int RX_SPARSE = 2;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func      = '0;
  logic [ACK_W-1:0]      in_ack_index = '0;
  logic [TIME_W-1:0]     in_now_ms    = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [KIND_W-1:0]     out_kind;
  logic [OIDX_W-1:0]     out_chunk_index;
  logic [OOFF_W-1:0]     out_byte_offset;
  logic [OCNT_W-1:0]     out_byte_count;
  logic [OTOT_W-1:0]     out_chunk_total;
  logic                  out_last;

  int mismatches;
  int outstanding;
  int results_checked;

  int burst_left   = 0;
  int useful_items = 0;
  int n_start      = 0;
  int n_ack        = 0;
  int n_poll       = 0;
  int n_unused     = 0;
  int n_settings   = 0;

  logic hold_req  = 1'b0;
  bit   hold_done = 1'b0;

  logic [TIME_W-1:0]    clock_ms;
  logic [MSGLEN_W-1:0]  cur_len;
  logic [TIMEOUT_W-1:0] cur_timeout;

  selective_repeat_sender_tracker_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_ack_index    (in_ack_index),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_chunk_index (out_chunk_index),
    .out_byte_offset (out_byte_offset),
    .out_byte_count  (out_byte_count),
    .out_chunk_total (out_chunk_total),
    .out_last        (out_last)
  );

  sender_tracker_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_ack_index    (in_ack_index),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_chunk_index (out_chunk_index),
    .out_byte_offset (out_byte_offset),
    .out_byte_count  (out_byte_count),
    .out_chunk_total (out_chunk_total),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

  // Result side: random stretches of open, half-open and mostly stalled ready, plus
  // one long hold-off on request so the block backs up into its input.
  initial begin : receiver
    int mode;
    int span;
    mode = RX_OPEN;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(RX_OPEN, RX_SPARSE);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_HALF: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted; gaps fall between bursts.
  task automatic issue(input logic [FUNC_W-1:0] func, input logic [ACK_W-1:0] ack,
                       input logic [TIME_W-1:0] now);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_func      <= func;
    in_ack_index <= ack;
    in_now_ms    <= now;
    do @(posedge clk); while (!in_ready);
    case (func)
      FUNC_START: n_start++;
      FUNC_ACK:   n_ack++;
      FUNC_POLL:  n_poll++;
      default:    n_unused++;
    endcase
  endtask

  // Stop offering and wait until every predicted result is out and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers while idle; the unused upper length bits get noise.
  task automatic apply_setting(input logic [MSGLEN_W-1:0] len, input logic [TIMEOUT_W-1:0] tmo);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {7'($urandom), len};
    settle();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_MSG_LEN, len_word);
      write_reg(REG_TIMEOUT, tmo);
    end else begin
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_MSG_LEN, len_word);
    end
    cur_len     = len;
    cur_timeout = tmo;
    n_settings++;
  endtask

  function automatic int chunks_of(logic [MSGLEN_W-1:0] len);
    int eff;
    eff = (len > LIMIT_BYTES) ? LIMIT_BYTES : len;
    return (eff + CHUNK_BYTES - 1) / CHUNK_BYTES;
  endfunction

  function automatic logic [MAX_CHUNKS-1:0] all_open(int total);
    logic [MAX_CHUNKS-1:0] mask;
    int i;
    mask = '0;
    for (i = 0; i < total; i++) begin
      mask[i] = 1'b1;
    end
    return mask;
  endfunction

  // Move the clock forward, mostly around the timeout, now and then by a wild jump.
  task automatic advance_clock();
    if ($urandom_range(0, 9) == 0) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 2 * cur_timeout + 2);
    end
  endtask

  // One transfer from start to done: acks in random order mixed with polls, plus
  // stray acks, unused codes and the occasional restart of a small transfer.
  task automatic run_transfer();
    int                    total;
    int                    ack_pct;
    int                    roll;
    logic [MAX_CHUNKS-1:0] open_mask;
    logic [ACK_W-1:0]      idx;
    total   = chunks_of(cur_len);
    ack_pct = (total > 16) ? 85 : 45;
    issue(FUNC_START, ACK_W'($urandom), clock_ms);
    useful_items++;
    open_mask = all_open(total);
    while (open_mask != '0) begin
      roll = $urandom_range(0, 99);
      if (roll < ack_pct) begin
        do idx = ACK_W'($urandom_range(0, total - 1)); while (!open_mask[idx]);
        issue(FUNC_ACK, idx, $urandom);
        open_mask[idx] = 1'b0;
        useful_items++;
      end else if (roll < ack_pct + 30) begin
        advance_clock();
        issue(FUNC_POLL, ACK_W'($urandom), clock_ms);
        useful_items++;
      end else if (roll < ack_pct + 38) begin
        idx = ACK_W'($urandom);
        issue(FUNC_ACK, idx, $urandom);
        if (idx < total) begin
          open_mask[idx] = 1'b0;
          useful_items++;
        end
      end else if (roll < ack_pct + 42) begin
        issue(FUNC_UNUSED, ACK_W'($urandom), $urandom);
      end else if (roll < ack_pct + 44 && total <= 16) begin
        advance_clock();
        issue(FUNC_START, ACK_W'($urandom), clock_ms);
        open_mask = all_open(total);
        useful_items++;
      end else begin
        advance_clock();
        issue(FUNC_POLL, ACK_W'($urandom), clock_ms);
        useful_items++;
      end
    end
    advance_clock();
    issue(FUNC_POLL, ACK_W'($urandom), clock_ms);
    useful_items++;
  endtask

  initial begin : stimulus
    int                   phase;
    int                   errors;
    logic [MSGLEN_W-1:0]  len;
    logic [TIMEOUT_W-1:0] tmo;

    cur_len     = '0;
    cur_timeout = TIMEOUT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle block under reset settings: polls and acks with no transfer, the
    // unused code, then an empty message that is done at the next poll.
    issue(FUNC_POLL, '0, 32'hFFFF_FFF0);
    issue(FUNC_ACK, '0, '0);
    issue(FUNC_UNUSED, 6'h3F, 32'hFFFF_FFFF);
    issue(FUNC_START, '0, 32'hFFFF_FFF0);
    issue(FUNC_POLL, '0, 32'hFFFF_FFF0);

    // Two chunks, the second partial, stamped just before the clock wraps.
    apply_setting(9'd7, TIMEOUT_RESET);
    issue(FUNC_START, 6'h3F, 32'hFFFF_FFF0);
    issue(FUNC_POLL, '0, 32'h0000_00B8);
    issue(FUNC_POLL, '0, 32'h0000_00B9);
    issue(FUNC_ACK, 6'd1, '0);
    issue(FUNC_ACK, 6'd2, '0);
    issue(FUNC_ACK, 6'h3F, '0);
    issue(FUNC_POLL, '0, 32'h8000_0000);
    // A start while active drops the old transfer and its acks.
    issue(FUNC_START, '0, 32'd5);
    issue(FUNC_ACK, 6'd0, 32'hFFFF_FFFF);
    issue(FUNC_ACK, 6'd1, '0);
    issue(FUNC_POLL, '0, 32'd6);
    issue(FUNC_POLL, '0, 32'd7);

    // Oversized length clamps to the full chunk count; zero timeout.
    apply_setting(9'h1FF, 16'd0);
    issue(FUNC_START, '0, '0);
    issue(FUNC_POLL, '0, '0);
    issue(FUNC_POLL, '0, 32'd1);

    // Exactly full message with the largest timeout, last chunk acked.
    apply_setting(9'd320, 16'hFFFF);
    issue(FUNC_START, '0, 32'hFFFF_FFFF);
    issue(FUNC_POLL, '0, 32'h0000_FFFE);
    issue(FUNC_ACK, 6'h3F, '0);
    issue(FUNC_POLL, '0, 32'h0000_FFFF);

    // Random phases, each under its own register setting.
    useful_items = 0;
    phase = 0;
    while (useful_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          len = 9'($urandom_range(1, 40));
          tmo = 16'd0;
        end
        1: begin
          len = 9'($urandom_range(1, 40));
          tmo = 16'hFFFF;
        end
        2: begin
          len = 9'h1FF;
          tmo = 16'($urandom_range(1, 300));
        end
        6: begin
          len = 9'd320;
          tmo = 16'($urandom_range(50, 400));
        end
        default: begin
          len = ($urandom_range(0, 7) == 0) ? 9'd0 : 9'($urandom_range(1, 40));
          tmo = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
        end
      endcase
      apply_setting(len, tmo);
      clock_ms = $urandom;
      if (phase == 2) begin
        hold_req <= 1'b1;
      end
      repeat ($urandom_range(1, 3)) run_transfer();
      phase++;
    end

    settle();
    errors = mismatches + outstanding;
    $display("Run drove %0d items (%0d starts, %0d acks, %0d polls, %0d unused codes)",
             n_start + n_ack + n_poll + n_unused, n_start, n_ack, n_poll, n_unused);
    $display("under %0d register settings; %0d results checked, %0d errors.",
             n_settings, results_checked, errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/srst_pkg.sv
sv/srst_stamp_ram.sv
sv/srst_elapsed_cmp.sv
sv/selective_repeat_sender_tracker_core.sv
sim/sender_tracker_checker.sv
sim/testbench.sv
